[src/fpn_pkg.sv]
// fpn_pkg: shared constants, types and arithmetic helpers for the fractal perlin noise block
// depends on nothing; used by the interfaces, the noise lane, the accumulator and the top level

package fpn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 8 + FRAC_BITS;
  localparam int HEIGHT_W  = 4 + FRAC_BITS;
  localparam int FADE_W    = FRAC_BITS + 1;
  localparam int QPOLY_W   = FRAC_BITS + 4;
  localparam int OFS_W     = FRAC_BITS + 2;
  localparam int GRAD_W    = FRAC_BITS + 3;
  localparam int NOISE_W   = FRAC_BITS + 2;
  localparam int AMP_W     = FRAC_BITS + 1;
  localparam int PERS_W    = 16;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NOISE_LAT = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 4'd1;
  localparam logic [CNT_W-1:0]     OCTAVE_COUNT_RST = 4'd7;
  localparam logic [PERS_W-1:0]    PERSISTENCE_RST  = 16'd52429;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << FRAC_BITS;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  typedef struct packed {
    logic [CNT_W-1:0]  octave_count;
    logic [PERS_W-1:0] persistence;
  } cfg_t;

  // gradient dot product: two offsets with hash-chosen signs
  function automatic logic signed [GRAD_W-1:0] grad_f(
    input logic [3:0] h,
    input logic signed [OFS_W-1:0] x,
    input logic signed [OFS_W-1:0] y,
    input logic signed [OFS_W-1:0] z
  );
    logic signed [OFS_W-1:0]  u;
    logic signed [OFS_W-1:0]  v;
    logic signed [GRAD_W-1:0] su;
    logic signed [GRAD_W-1:0] sv;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    su = {u[OFS_W-1], u};
    sv = {v[OFS_W-1], v};
    if (h[0]) su = -su;
    if (h[1]) sv = -sv;
    return su + sv;
  endfunction

  // lerp a + floor(w*(b-a) / 2^F)
  function automatic logic signed [GRAD_W-1:0] mix_f(
    input logic [FADE_W-1:0] w,
    input logic signed [GRAD_W-1:0] a,
    input logic signed [GRAD_W-1:0] b
  );
    logic signed [GRAD_W:0]             d;
    logic signed [FADE_W+GRAD_W+1:0]    p;
    d = {b[GRAD_W-1], b} - {a[GRAD_W-1], a};
    p = $signed({{(GRAD_W+1){1'b0}}, w}) * $signed({{(FADE_W+1){d[GRAD_W]}}, d});
    return a + p[FRAC_BITS +: GRAD_W];
  endfunction

endpackage

[src/fpn_ifs.sv]
// fpn_ifs: valid/ready channel interfaces for points and heights
// depends on fpn_pkg for the field widths

interface fpn_point_if;
  logic                            valid;
  logic                            ready;
  logic [fpn_pkg::COORD_W-1:0]     coord_x;
  logic [fpn_pkg::COORD_W-1:0]     coord_y;
  logic [fpn_pkg::COORD_W-1:0]     coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface fpn_height_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpn_pkg::HEIGHT_W-1:0] height;
  modport source (output valid, height, input ready);
  modport sink   (input valid, height, output ready);
endinterface

[src/fpn_noise.sv]
// fpn_noise: one octave of improved perlin noise as a six-stage pipeline
// depends on fpn_pkg (permutation table, gradient and lerp helpers)

module fpn_noise (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [fpn_pkg::COORD_W-1:0]         x_i,
  input  logic [fpn_pkg::COORD_W-1:0]         y_i,
  input  logic [fpn_pkg::COORD_W-1:0]         z_i,
  output logic signed [fpn_pkg::NOISE_W-1:0]  noise_o
);
  localparam int F  = fpn_pkg::FRAC_BITS;
  localparam int GW = fpn_pkg::GRAD_W;
  localparam int OW = fpn_pkg::OFS_W;
  localparam int FW = fpn_pkg::FADE_W;
  localparam int QW = fpn_pkg::QPOLY_W;
  localparam int PW = 2 * F + 6;
  localparam logic signed [OW-1:0] ONE_S = OW'(1) << F;
  localparam logic signed [GW-1:0] N_HI  = GW'((1 << (F + 1)) - 1);
  localparam logic signed [GW-1:0] N_LO  = -GW'(1 << (F + 1));

  // stage 1: first hash level, t^2 and fade polynomial
  logic [F-1:0]  t [3];
  logic [7:0]    a_d, b_d;
  logic [F-1:0]  t1_q [3];
  logic [F-1:0]  t2_q [3];
  logic [QW-1:0] q1_q [3];
  logic [7:0]    a_q, b_q, z1_q;

  assign t[0] = x_i[F-1:0];
  assign t[1] = y_i[F-1:0];
  assign t[2] = z_i[F-1:0];
  assign a_d  = fpn_pkg::PERM[x_i[F +: 8]] + y_i[F +: 8];
  assign b_d  = fpn_pkg::PERM[x_i[F +: 8] + 8'd1] + y_i[F +: 8];

  for (genvar i = 0; i < 3; i++) begin : g_s1
    logic [2*F-1:0] tt;
    logic [PW-1:0]  qs;
    assign tt = (2*F)'(t[i]) * (2*F)'(t[i]);
    assign qs = PW'(tt) * PW'(6) + (PW'(10) << (2 * F)) - ((PW'(t[i]) * PW'(15)) << F);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t1_q[i] <= t[i];
        t2_q[i] <= tt[F +: F];
        q1_q[i] <= qs[F +: QW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      b_q  <= b_d;
      z1_q <= z_i[F +: 8];
    end
  end

  // stage 2: second hash level, t^3
  logic [7:0]    aa_q, ab_q, ba_q, bb_q;
  logic [F-1:0]  t_s2_q [3];
  logic [F-1:0]  t3_q [3];
  logic [QW-1:0] q2_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_s2
    logic [2*F-1:0] p3;
    assign p3 = (2*F)'(t2_q[i]) * (2*F)'(t1_q[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_s2_q[i] <= t1_q[i];
        t3_q[i]   <= p3[F +: F];
        q2_q[i]   <= q1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa_q <= fpn_pkg::PERM[a_q] + z1_q;
      ab_q <= fpn_pkg::PERM[a_q + 8'd1] + z1_q;
      ba_q <= fpn_pkg::PERM[b_q] + z1_q;
      bb_q <= fpn_pkg::PERM[b_q + 8'd1] + z1_q;
    end
  end

  // stage 3: corner gradients and fade curves
  logic signed [OW-1:0] o0 [3];
  logic signed [OW-1:0] o1 [3];
  logic [7:0]           hsh [8];
  logic signed [GW-1:0] g_q [8];
  logic [FW-1:0]        f_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_s3
    logic [F+QW-1:0] pf;
    assign o0[i] = $signed({2'b00, t_s2_q[i]});
    assign o1[i] = o0[i] - ONE_S;
    assign pf    = (F+QW)'(t3_q[i]) * (F+QW)'(q2_q[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i] <= pf[F +: FW];
      end
    end
  end

  assign hsh[0] = fpn_pkg::PERM[aa_q];
  assign hsh[1] = fpn_pkg::PERM[ba_q];
  assign hsh[2] = fpn_pkg::PERM[ab_q];
  assign hsh[3] = fpn_pkg::PERM[bb_q];
  assign hsh[4] = fpn_pkg::PERM[aa_q + 8'd1];
  assign hsh[5] = fpn_pkg::PERM[ba_q + 8'd1];
  assign hsh[6] = fpn_pkg::PERM[ab_q + 8'd1];
  assign hsh[7] = fpn_pkg::PERM[bb_q + 8'd1];

  // corner k: bit 0 picks x side, bit 1 y side, bit 2 z side
  for (genvar k = 0; k < 8; k++) begin : g_grad
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        g_q[k] <= fpn_pkg::grad_f(hsh[k][3:0],
                                  k[0] ? o1[0] : o0[0],
                                  k[1] ? o1[1] : o0[1],
                                  k[2] ? o1[2] : o0[2]);
      end
    end
  end

  // stage 4..6: trilinear blend along x, y, then z
  logic signed [GW-1:0] l_q [4];
  logic signed [GW-1:0] m_q [2];
  logic [FW-1:0]        fv4_q, fw4_q, fw5_q;
  logic signed [GW-1:0] n_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        l_q[j] <= fpn_pkg::mix_f(f_q[0], g_q[2*j], g_q[2*j+1]);
      end
      fv4_q  <= f_q[1];
      fw4_q  <= f_q[2];
      m_q[0] <= fpn_pkg::mix_f(fv4_q, l_q[0], l_q[1]);
      m_q[1] <= fpn_pkg::mix_f(fv4_q, l_q[2], l_q[3]);
      fw5_q  <= fw4_q;
    end
  end

  always_comb begin
    n_d = fpn_pkg::mix_f(fw5_q, m_q[0], m_q[1]);
    if (n_d > N_HI) n_d = N_HI;
    if (n_d < N_LO) n_d = N_LO;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      noise_o <= n_d[fpn_pkg::NOISE_W-1:0];
    end
  end

endmodule

[src/fpn_accum.sv]
// fpn_accum: octave weighting and saturating sum, one stage per octave
// depends on fpn_pkg (widths, amplitude one, config struct)

module fpn_accum #(
  parameter int OCTAVE_MAX = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  fpn_pkg::cfg_t                        cfg_i,
  input  logic                                 valid_i,
  input  logic signed [fpn_pkg::NOISE_W-1:0]   noise_i [OCTAVE_MAX],
  output logic                                 valid_o,
  output logic signed [fpn_pkg::HEIGHT_W-1:0]  height_o
);
  localparam int F  = fpn_pkg::FRAC_BITS;
  localparam int NW = fpn_pkg::NOISE_W;
  localparam int HW = fpn_pkg::HEIGHT_W;
  localparam int AW = fpn_pkg::AMP_W;
  localparam int MW = NW + AW + 1;
  localparam logic signed [HW:0] S_HI = (HW+1)'((1 << (HW - 1)) - 1);
  localparam logic signed [HW:0] S_LO = -(HW+1)'(1 << (HW - 1));

  logic                 vld_q [OCTAVE_MAX];
  logic signed [HW-1:0] sum_q [OCTAVE_MAX];
  logic [AW-1:0]        amp_q [OCTAVE_MAX];
  logic signed [NW-1:0] vec_q [OCTAVE_MAX][OCTAVE_MAX];

  for (genvar k = 0; k < OCTAVE_MAX; k++) begin : g_oct
    logic                 vld_in;
    logic signed [HW-1:0] sum_in;
    logic [AW-1:0]        amp_in;
    logic signed [NW-1:0] vec_in [OCTAVE_MAX];
    logic signed [MW-1:0] prod;
    logic signed [HW:0]   acc;
    logic signed [HW-1:0] sum_d;
    logic [AW+15:0]       amp_p;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign sum_in = '0;
      assign amp_in = fpn_pkg::AMP_ONE;
      assign vec_in = noise_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign sum_in = sum_q[k-1];
      assign amp_in = amp_q[k-1];
      assign vec_in = vec_q[k-1];
    end

    assign prod  = $signed({{(AW+1){vec_in[k][NW-1]}}, vec_in[k]})
                 * $signed({{(NW+1){1'b0}}, amp_in});
    assign amp_p = (AW+16)'(amp_in) * (AW+16)'(cfg_i.persistence);

    always_comb begin
      acc = {sum_in[HW-1], sum_in} + (HW+1)'($signed(prod[MW-1:F]));
      if (acc > S_HI) acc = S_HI;
      if (acc < S_LO) acc = S_LO;
      sum_d = (fpn_pkg::CNT_W'(k) < cfg_i.octave_count) ? acc[HW-1:0] : sum_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[k] <= sum_d;
        amp_q[k] <= amp_p[16 +: AW];
        vec_q[k] <= vec_in;
      end
    end
  end

  assign valid_o  = vld_q[OCTAVE_MAX-1];
  assign height_o = sum_q[OCTAVE_MAX-1];

endmodule

[src/fractal_perlin_noise_3d_top.sv]
// fractal_perlin_noise_3d_top: fractal improved perlin noise, one point per cycle when not stalled
// depends on fpn_pkg, fpn_ifs, fpn_noise and fpn_accum
//
// usage
//   pt_i carries one point word per handshake: coord_x/y/z, unsigned Q8.16,
//   integer parts wrap at 256. ht_o returns one height word per point, signed
//   Q3.16, saturated, in the order the points went in.
//   configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 octave_count, 1 persistence Q0.16); other indexes are dropped.
//   write only while no point is in flight.
// pipeline
//   the path has six noise stages, then one weighting/summing stage per
//   octave. every octave has its own noise lane, so throughput is one point
//   per cycle while ht_o is not stalled.
// reset
//   rst_ni clears all valid bits and loads octave_count 7, persistence 0.8.
// stall
//   the whole pipeline advances as one; when ht_o holds a word that is not
//   taken, every stage holds and pt_i.ready is low, so nothing is dropped or repeated.

module fractal_perlin_noise_3d_top #(
  parameter int OCTAVE_MAX = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  fpn_point_if.sink                             pt_i,
  fpn_height_if.source                          ht_o,
  input  logic                                  cfg_we_i,
  input  logic [fpn_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [fpn_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  localparam int NL = fpn_pkg::NOISE_LAT;
  // signed noise range of a single octave
  localparam logic signed [fpn_pkg::HEIGHT_W-1:0] ONE_OCT_HI =
    fpn_pkg::HEIGHT_W'((1 << (fpn_pkg::FRAC_BITS + 1)) - 1);
  localparam logic signed [fpn_pkg::HEIGHT_W-1:0] ONE_OCT_LO =
    -fpn_pkg::HEIGHT_W'(1 << (fpn_pkg::FRAC_BITS + 1));

  // configuration registers
  fpn_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count <= fpn_pkg::OCTAVE_COUNT_RST;
      cfg_q.persistence  <= fpn_pkg::PERSISTENCE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fpn_pkg::CFG_OCTAVE_COUNT) begin
        cfg_q.octave_count <= cfg_data_i[fpn_pkg::CNT_W-1:0];
      end else if (cfg_idx_i == fpn_pkg::CFG_PERSISTENCE) begin
        cfg_q.persistence <= cfg_data_i[fpn_pkg::PERS_W-1:0];
      end
    end
  end

  // global advance: move when the output slot is empty or being taken
  logic en;
  assign en         = !ht_o.valid || ht_o.ready;
  assign pt_i.ready = en;

  // valid bits for the noise stages
  logic [NL-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NL-2:0], pt_i.valid};
    end
  end

  // one noise lane per octave, coordinates doubled by shifting, wrap at 256
  logic signed [fpn_pkg::NOISE_W-1:0] noise [OCTAVE_MAX];

  for (genvar o = 0; o < OCTAVE_MAX; o++) begin : g_lane
    logic [fpn_pkg::COORD_W-1:0] sx, sy, sz;
    assign sx = pt_i.coord_x << o;
    assign sy = pt_i.coord_y << o;
    assign sz = pt_i.coord_z << o;

    fpn_noise u_noise (
      .clk_i   (clk_i),
      .en_i    (en),
      .x_i     (sx),
      .y_i     (sy),
      .z_i     (sz),
      .noise_o (noise[o])
    );
  end

  // weighting and saturating sum over octaves
  fpn_accum #(
    .OCTAVE_MAX (OCTAVE_MAX)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .valid_i  (vld_q[NL-1]),
    .noise_i  (noise),
    .valid_o  (ht_o.valid),
    .height_o (ht_o.height)
  );

  // no octaves summed means a flat zero height
  a_zero_octaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ht_o.valid && cfg_q.octave_count == '0) |-> (ht_o.height == '0))
    else $error("height nonzero with zero octaves");

  // a single octave stays inside the noise range
  a_one_octave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ht_o.valid && cfg_q.octave_count == fpn_pkg::CNT_W'(1)) |->
    (ht_o.height >= ONE_OCT_LO && ht_o.height <= ONE_OCT_HI))
    else $error("single octave height out of noise range");

  // a stalled pipeline keeps its noise stage valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("noise stage valid bits moved during stall");

endmodule
